// ----- rtl/mfs_pkg.sv -----
`default_nettype none
package mfs_pkg;

    localparam int RES_W   = 13;
    localparam int B_W     = 17;
    localparam int POS_W   = 16;
    localparam int TAG_W   = 32;
    localparam int PIX_W   = 14;
    localparam int WT_W    = 16;
    localparam int NIDX_W  = 12;   // integer pixel index of the scaled position
    localparam int D_W     = 17;   // signed offset from pixel center, Q.16
    localparam int AW_W    = 18;   // per-axis weight, signed Q.15
    localparam int TAP_W   = 3;
    localparam int CO_W    = 26;   // polynomial coefficients, times 6, Q.17
    localparam int H_W     = 28;   // Horner accumulator
    localparam int P_W     = 46;   // Horner product
    localparam int N_W     = 23;   // biased dividend over 8
    localparam int M_W     = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_RES_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COEFF = 2'd2;

    localparam logic [RES_W-1:0] RES_RESET = 13'd1024;
    localparam logic [RES_W-1:0] RES_MAX   = 13'd4096;
    localparam logic [B_W-1:0]   B_RESET   = 17'd21845;
    localparam logic [B_W-1:0]   B_ONE     = 17'd65536;

    // floor(2^26 / 3); the quotient it gives is short by at most one
    localparam logic [24:0]      RECIP3    = 25'd22369621;
    // 3 * 2^23 keeps the dividend positive and divides evenly by 24
    localparam logic signed [H_W-1:0] DIV_BIAS = 28'sd25165824;
    localparam logic signed [22:0]    Q_BIAS   = 23'sd1048576;

    localparam logic signed [WT_W-1:0] W_MAX = 16'sh7fff;
    localparam logic signed [WT_W-1:0] W_MIN = 16'sh8000;

    typedef struct packed {
        logic             vld;
        logic [TAP_W-1:0] tap;
    } mfs_tap_t;

    function automatic int ent_w(input int taps);
        return 2 * taps * AW_W + 2 * NIDX_W + TAG_W;
    endfunction

    function automatic logic [RES_W-1:0] clamp_res(input logic [RES_W-1:0] r);
        if (r == '0)
            return RES_W'(1);
        if (r > RES_MAX)
            return RES_MAX;
        return r;
    endfunction

    function automatic logic [B_W-1:0] clamp_b(input logic [B_W-1:0] b);
        return (b > B_ONE) ? B_ONE : b;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/mfs_if.sv -----
`default_nettype none
interface mfs_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pos_u;
    logic [15:0] pos_v;
    logic [31:0] sample_tag;

    modport source (output valid, output pos_u, output pos_v, output sample_tag,
                    input ready);
    modport sink   (input valid, input pos_u, input pos_v, input sample_tag,
                    output ready);
endinterface

interface mfs_out_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] pixel_col;
    logic signed [13:0] pixel_row;
    logic signed [15:0] weight;
    logic [31:0]        payload;
    logic               last_of_run;

    modport source (output valid, output pixel_col, output pixel_row, output weight,
                    output payload, output last_of_run, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input weight,
                    input payload, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/mitchell_filter_splat.sv -----
// Cubic reconstruction splat: one sample in, TAPS x TAPS weighted pixel beats out.
// sample_in carries pos_u/pos_v (Q0.16) and sample_tag; result_out carries
// pixel_col, pixel_row, weight (Q1.15, saturated), payload and last_of_run,
// rows outer and columns inner. Both channels move a beat when valid and ready
// are high. The cfg port writes res_x, res_y and b_coeff by index on cfg_we;
// write it only while no sample is in flight.
// Throughput: one result per cycle while result_out is ready; the output beat
// rate is the limit. The front end scales the position and runs both axis
// kernels (five-stage pipelines), then parks the weights in a two-entry queue,
// so it works ahead on the next sample while the back end emits the current one.
// When result_out stalls, the output register holds its beat, the back end
// waits, the queue fills and sample_in drops ready.
// Reset clears all control state and loads res_x = res_y = 1024, b_coeff = 21845.
`default_nettype none
module mitchell_filter_splat #(
    parameter int TAPS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mfs_in_if.sink                            sample_in,
    mfs_out_if.source                         result_out,
    input  logic                              cfg_we,
    input  logic [mfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mfs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mfs_pkg::*;

    localparam int EW = ent_w(TAPS);

    logic [RES_W-1:0] res_x_reg, res_y_reg;
    logic [B_W-1:0]   b_coeff_reg;
    logic             push_valid, push_ready, q_valid, pop;
    logic [EW-1:0]    push_data, q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_x_reg   <= RES_RESET;
            res_y_reg   <= RES_RESET;
            b_coeff_reg <= B_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RES_X:   res_x_reg   <= cfg_data[RES_W-1:0];
                CFG_RES_Y:   res_y_reg   <= cfg_data[RES_W-1:0];
                CFG_B_COEFF: b_coeff_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    mfs_front #(.TAPS(TAPS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .res_x      (res_x_reg),
        .res_y      (res_y_reg),
        .b_coeff    (b_coeff_reg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    mfs_queue #(.W(EW)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop        (pop)
    );

    mfs_back #(.TAPS(TAPS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule
`default_nettype wire

// ----- rtl/mfs_kernel.sv -----
`default_nettype none
module mfs_kernel #(
    parameter int TAPS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mfs_pkg::mfs_tap_t                 issue,
    input  logic signed [mfs_pkg::D_W-1:0]    d,
    input  logic [mfs_pkg::B_W-1:0]           bq,
    output mfs_pkg::mfs_tap_t                 res,
    output logic signed [mfs_pkg::AW_W-1:0]   w
);
    import mfs_pkg::*;

    localparam int HALF = TAPS / 2;
    localparam logic signed [19:0] K_OFS = 20'(HALF * 65536);

    logic signed [19:0]     t;
    logic [19:0]            x;
    logic                   seg_a;
    logic                   seg_b;
    logic signed [CO_W-1:0] bs, cs, a3, a2, a0, c3, c2, c1, c0;
    logic signed [H_W-1:0]  h1, h2, h3, v;
    logic [N_W-1:0]         n;
    logic [21:0]            q, qc;
    logic [23:0]            r;

    mfs_tap_t               sa_tap_reg, sb_tap_reg, sc_tap_reg, sd_tap_reg, se_tap_reg;
    logic signed [P_W-1:0]  sa_p_reg, sb_p_reg, sc_p_reg;
    logic signed [17:0]     sa_x_reg, sb_x_reg;
    logic                   sa_a_reg, sb_a_reg, sc_a_reg;
    logic                   sa_z_reg, sb_z_reg, sc_z_reg, sd_z_reg;
    logic [N_W-1:0]         sd_n_reg;
    logic [M_W-1:0]         sd_m_reg;
    logic signed [AW_W-1:0] se_w_reg;

    always_comb
    begin
        bs = signed'(CO_W'({bq, 1'b0}));
        cs = signed'(CO_W'(B_ONE)) - signed'(CO_W'(bq));
        a3 = CO_W'(12 * 131072 - 9 * bs - 6 * cs);
        a2 = CO_W'(-18 * 131072 + 12 * bs + 6 * cs);
        a0 = CO_W'(6 * 131072 - 2 * bs);
        c3 = CO_W'(-bs - 6 * cs);
        c2 = CO_W'(6 * bs + 30 * cs);
        c1 = CO_W'(-12 * bs - 48 * cs);
        c0 = CO_W'(8 * bs + 24 * cs);
    end

    always_comb
    begin
        t     = 20'(d) + signed'({1'b0, issue.tap, 16'h0}) - K_OFS;
        x     = t[19] ? 20'(-t) : 20'(t);
        seg_a = (x < 20'd65536);
        seg_b = !seg_a && (x < 20'd131072);
    end

    always_comb
    begin
        h1 = H_W'(sa_p_reg >>> 16) + H_W'(sa_a_reg ? a2 : c2);
        h2 = H_W'(sb_p_reg >>> 16) + (sb_a_reg ? H_W'(0) : H_W'(c1));
        h3 = H_W'(sc_p_reg >>> 16) + H_W'(sc_a_reg ? a0 : c0);
        v  = h3 + H_W'(12) + DIV_BIAS;
        n  = N_W'(v >>> 3);
        q  = sd_m_reg[47:26];
        r  = 24'(sd_n_reg) - (24'({q, 1'b0}) + 24'(q));
        qc = (r >= 24'd3) ? q + 22'd1 : q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_tap_reg <= '0;
            sb_tap_reg <= '0;
            sc_tap_reg <= '0;
            sd_tap_reg <= '0;
            se_tap_reg <= '0;
        end
        else
        begin
            sa_tap_reg <= issue;
            sb_tap_reg <= sa_tap_reg;
            sc_tap_reg <= sb_tap_reg;
            sd_tap_reg <= sc_tap_reg;
            se_tap_reg <= sd_tap_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_x_reg <= signed'({1'b0, x[16:0]});
        sa_a_reg <= seg_a;
        sa_z_reg <= !seg_a && !seg_b;
        sa_p_reg <= H_W'(seg_a ? a3 : c3) * signed'({1'b0, x[16:0]});

        sb_x_reg <= sa_x_reg;
        sb_a_reg <= sa_a_reg;
        sb_z_reg <= sa_z_reg;
        sb_p_reg <= h1 * sa_x_reg;

        sc_a_reg <= sb_a_reg;
        sc_z_reg <= sb_z_reg;
        sc_p_reg <= h2 * sb_x_reg;

        sd_z_reg <= sc_z_reg;
        sd_n_reg <= n;
        sd_m_reg <= M_W'(n) * M_W'(RECIP3);

        // quotient minus the bias is the rounded axis weight
        se_w_reg <= sd_z_reg ? '0 : AW_W'(signed'({1'b0, qc}) - Q_BIAS);
    end

    assign res = se_tap_reg;
    assign w   = se_w_reg;

endmodule
`default_nettype wire

// ----- rtl/mfs_front.sv -----
`default_nettype none
module mfs_front #(
    parameter int TAPS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mfs_in_if.sink                           sample_in,
    input  logic [mfs_pkg::RES_W-1:0]        res_x,
    input  logic [mfs_pkg::RES_W-1:0]        res_y,
    input  logic [mfs_pkg::B_W-1:0]          b_coeff,
    output logic                             push_valid,
    output logic [mfs_pkg::ent_w(TAPS)-1:0]  push_data,
    input  logic                             push_ready
);
    import mfs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_FEED  = 3'd2;
    localparam logic [2:0] ST_PUSH  = 3'd3;

    logic [2:0]             state_reg, state_next;
    logic [TAP_W-1:0]       tap_reg, tap_next;
    logic [TAP_W-1:0]       got_reg, got_next;
    logic [POS_W-1:0]       pos_u_reg, pos_v_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [NIDX_W-1:0]      nu_reg, nv_reg;
    logic signed [D_W-1:0]  du_reg, dv_reg;
    logic signed [AW_W-1:0] wu_reg [TAPS];
    logic signed [AW_W-1:0] wv_reg [TAPS];
    logic [28:0]            pu, pv;
    logic                   take;
    mfs_tap_t               issue, ru, rv;
    logic signed [AW_W-1:0] ku_w, kv_w;
    logic [B_W-1:0]         bq;

    assign bq         = clamp_b(b_coeff);
    assign push_valid = (state_reg == ST_PUSH) && (got_reg == TAP_W'(TAPS));
    assign sample_in.ready = (state_reg == ST_IDLE) || (push_valid && push_ready);
    assign take       = sample_in.valid && sample_in.ready;
    assign issue.vld  = (state_reg == ST_FEED);
    assign issue.tap  = tap_reg;
    assign pu = 29'(clamp_res(res_x)) * 29'(pos_u_reg);
    assign pv = 29'(clamp_res(res_y)) * 29'(pos_v_reg);

    mfs_kernel #(.TAPS(TAPS)) u_ku (
        .clk(clk), .rst_n(rst_n), .issue(issue), .d(du_reg), .bq(bq), .res(ru), .w(ku_w)
    );
    mfs_kernel #(.TAPS(TAPS)) u_kv (
        .clk(clk), .rst_n(rst_n), .issue(issue), .d(dv_reg), .bq(bq), .res(rv), .w(kv_w)
    );

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        got_next   = ru.vld ? got_reg + TAP_W'(1) : got_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                tap_next   = '0;
                state_next = ST_FEED;
            end
            ST_FEED:
            begin
                tap_next = tap_reg + TAP_W'(1);
                if (tap_reg == TAP_W'(TAPS - 1))
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (push_valid && push_ready)
                begin
                    got_next   = '0;
                    state_next = take ? ST_SCALE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
            got_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            got_reg   <= got_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pos_u_reg <= sample_in.pos_u;
            pos_v_reg <= sample_in.pos_v;
            tag_reg   <= sample_in.sample_tag;
        end
        if (state_reg == ST_SCALE)
        begin
            nu_reg <= pu[27:16];
            nv_reg <= pv[27:16];
            du_reg <= signed'({1'b0, pu[15:0]}) - 17'sd32768;
            dv_reg <= signed'({1'b0, pv[15:0]}) - 17'sd32768;
        end
        for (int g = 0; g < TAPS; g++)
        begin
            if (ru.vld && ru.tap == TAP_W'(g))
                wu_reg[g] <= ku_w;
            if (rv.vld && rv.tap == TAP_W'(g))
                wv_reg[g] <= kv_w;
        end
    end

    always_comb
    begin
        push_data = '0;
        for (int g = 0; g < TAPS; g++)
        begin
            push_data[g * AW_W +: AW_W]          = wu_reg[g];
            push_data[(TAPS + g) * AW_W +: AW_W] = wv_reg[g];
        end
        push_data[2 * TAPS * AW_W +: NIDX_W]                = nu_reg;
        push_data[2 * TAPS * AW_W + NIDX_W +: NIDX_W]       = nv_reg;
        push_data[2 * TAPS * AW_W + 2 * NIDX_W +: TAG_W]    = tag_reg;
    end

endmodule
`default_nettype wire

// ----- rtl/mfs_queue.sv -----
`default_nettype none
module mfs_queue #(
    parameter int W = 200
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  logic [W-1:0] push_data,
    output logic         push_ready,
    output logic         pop_valid,
    output logic [W-1:0] pop_data,
    input  logic         pop
);
    logic [W-1:0] slot_reg [2];
    logic         wr_reg, rd_reg;
    logic [1:0]   cnt_reg;
    logic         do_push;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            if (do_push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ----- rtl/mfs_back.sv -----
`default_nettype none
module mfs_back #(
    parameter int TAPS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  logic [mfs_pkg::ent_w(TAPS)-1:0]  q_data,
    output logic                             pop,
    mfs_out_if.source                        result_out
);
    import mfs_pkg::*;

    localparam int EW = ent_w(TAPS);

    logic [EW-1:0]          cur_reg;
    logic                   cur_valid_reg;
    logic [TAP_W-1:0]       i_reg, j_reg;
    logic                   out_valid_reg;
    logic signed [PIX_W-1:0] col_reg, row_reg;
    logic signed [WT_W-1:0] w_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic                   last_reg;

    logic                   adv, last;
    logic signed [AW_W-1:0] wa, wb;
    logic signed [35:0]     prod;
    logic signed [20:0]     wr;
    logic signed [WT_W-1:0] wsat;
    logic [NIDX_W-1:0]      nu, nv;
    logic signed [PIX_W-1:0] col, row;

    assign adv  = cur_valid_reg && (!out_valid_reg || result_out.ready);
    assign last = (i_reg == TAP_W'(TAPS - 1)) && (j_reg == TAP_W'(TAPS - 1));
    assign pop  = q_valid && (!cur_valid_reg || (adv && last));
    assign nu   = cur_reg[2 * TAPS * AW_W +: NIDX_W];
    assign nv   = cur_reg[2 * TAPS * AW_W + NIDX_W +: NIDX_W];

    always_comb
    begin
        wa = '0;
        wb = '0;
        for (int g = 0; g < TAPS; g++)
        begin
            if (i_reg == TAP_W'(g))
                wa = cur_reg[g * AW_W +: AW_W];
            if (j_reg == TAP_W'(g))
                wb = cur_reg[(TAPS + g) * AW_W +: AW_W];
        end
        prod = 36'(wa) * 36'(wb) + 36'sd16384;
        wr   = 21'(prod >>> 15);
        if (wr > 21'(W_MAX))
            wsat = W_MAX;
        else if (wr < 21'(W_MIN))
            wsat = W_MIN;
        else
            wsat = WT_W'(wr);
        col = signed'({2'b00, nu}) + signed'(PIX_W'(i_reg)) - PIX_W'(TAPS / 2);
        row = signed'({2'b00, nv}) + signed'(PIX_W'(j_reg)) - PIX_W'(TAPS / 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                i_reg         <= '0;
                j_reg         <= '0;
            end
            else if (adv)
            begin
                if (last)
                    cur_valid_reg <= 1'b0;
                if (i_reg == TAP_W'(TAPS - 1))
                begin
                    i_reg <= '0;
                    j_reg <= j_reg + TAP_W'(1);
                end
                else
                    i_reg <= i_reg + TAP_W'(1);
            end
            if (adv)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_data;
        if (adv)
        begin
            col_reg  <= col;
            row_reg  <= row;
            w_reg    <= wsat;
            tag_reg  <= cur_reg[2 * TAPS * AW_W + 2 * NIDX_W +: TAG_W];
            last_reg <= last;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.pixel_col   = col_reg;
    assign result_out.pixel_row   = row_reg;
    assign result_out.weight      = w_reg;
    assign result_out.payload     = tag_reg;
    assign result_out.last_of_run = last_reg;

endmodule
`default_nettype wire

// ----- rtl/mfs_checker.sv -----
`default_nettype none
module mfs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [13:0] pixel_col,
    input logic signed [13:0] pixel_row,
    input logic signed [15:0] weight,
    input logic [31:0]        payload,
    input logic               last_of_run
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_col) && $stable(weight)
            && $stable(payload) && $stable(last_of_run))
        else $error("stalled result beat changed");

    // within a run the next beat follows at once
    a_run_dense: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && $stable(payload))
        else $error("gap or payload change inside a run");

    a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pixel_col >= -14'sd3 && pixel_col <= 14'sd4098
            && pixel_row >= -14'sd3 && pixel_row <= 14'sd4098)
        else $error("pixel index out of range");
endmodule

bind mitchell_filter_splat mfs_checker u_mfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .pixel_col   (result_out.pixel_col),
    .pixel_row   (result_out.pixel_row),
    .weight      (result_out.weight),
    .payload     (result_out.payload),
    .last_of_run (result_out.last_of_run)
);
`default_nettype wire
